// ===== src/crc32c_word_engine_top_defines.svh =====
// assertion macros shared by the crc32c word engine checkers
// no dependencies; included by the checker file only
`ifndef CRC32C_WORD_ENGINE_TOP_DEFINES_SVH
`define CRC32C_WORD_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/crc32c_pkg.sv =====
// shared types, constants and elaboration-time matrix builders for crc32c
// no dependencies; imported by the crc32c design modules and the testbench
package crc32c_pkg;

    localparam logic [31:0] CRC_ALL_ONES  = 32'hffff_ffff;
    // reflected castagnoli polynomial (0x1edc6f41 bit-reversed)
    localparam logic [31:0] CRC_POLY_REFL = 32'h82f6_3b78;
    localparam int          CRC_BYTES     = 4;

    // one input transaction as held in the input register
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        start_req;
        logic [31:0] seed;
    } t_crc_item;

    // 32x32 gf(2) matrix, one column per source bit
    typedef logic [31:0][31:0]                t_crc_mat;
    typedef logic [CRC_BYTES-1:0][31:0][31:0] t_crc_mat_set;

    // bitwise lsb-first fold of the first n bytes; elaboration use only
    function automatic logic [31:0] crc_fold_ref(input logic [31:0] r_in,
                                                 input logic [31:0] word,
                                                 input int unsigned n);
        logic [31:0] r;
        logic        lsb;
        r = r_in;
        for (int k = 0; k < CRC_BYTES; k++) begin
            if (k < n) begin
                r = r ^ {24'd0, word[8*k +: 8]};
                for (int b = 0; b < 8; b++) begin
                    lsb = r[0];
                    r   = r >> 1;
                    if (lsb) begin
                        r = r ^ CRC_POLY_REFL;
                    end
                end
            end
        end
        return r;
    endfunction

    // remainder-to-remainder matrices for 1..4 bytes
    function automatic t_crc_mat_set crc_state_set();
        t_crc_mat_set m;
        for (int n = 0; n < CRC_BYTES; n++) begin
            for (int j = 0; j < 32; j++) begin
                m[n][j] = crc_fold_ref(32'd1 << j, 32'd0, n + 1);
            end
        end
        return m;
    endfunction

    // data-to-remainder matrices for 1..4 bytes
    function automatic t_crc_mat_set crc_data_set();
        t_crc_mat_set m;
        for (int n = 0; n < CRC_BYTES; n++) begin
            for (int j = 0; j < 32; j++) begin
                m[n][j] = crc_fold_ref(32'd0, 32'd1 << j, n + 1);
            end
        end
        return m;
    endfunction

    localparam t_crc_mat_set CRC_STATE_MAT = crc_state_set();
    localparam t_crc_mat_set CRC_DATA_MAT  = crc_data_set();

    // gf(2) matrix times vector: xor of the columns selected by v
    function automatic logic [31:0] crc_mat_mul(input t_crc_mat m, input logic [31:0] v);
        logic [31:0] acc;
        acc = '0;
        for (int j = 0; j < 32; j++) begin
            if (v[j]) begin
                acc = acc ^ m[j];
            end
        end
        return acc;
    endfunction

endpackage

// ===== src/crc32c_in_stage.sv =====
// input register stage: captures one transaction and holds it until the update
// depends on crc32c_pkg
module crc32c_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  crc32c_pkg::t_crc_item i_item,
    input  logic                 i_adv,
    output logic                 o_item_valid,
    output crc32c_pkg::t_crc_item o_item
);
    import crc32c_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_crc_item r_item;
    logic      take;

    // free when empty or when the held item moves on this cycle
    assign o_in_ready = !r_valid || i_adv;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ===== src/crc32c_update.sv =====
// running remainder register and the one-pass xor-matrix update for 0..4 bytes
// depends on crc32c_pkg
module crc32c_update (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  crc32c_pkg::t_crc_item i_item,
    output logic [31:0]          o_next_rem
);
    import crc32c_pkg::*;

    logic [31:0]                 r_remainder;
    logic [31:0]                 n_remainder;
    logic [31:0]                 base;
    logic [CRC_BYTES-1:0][31:0]  cand;
    logic [1:0]                  lane;
    logic                        fold_en;

    // starting value: inverted seed or the running remainder
    assign base = i_item.start_req ? (i_item.seed ^ CRC_ALL_ONES) : r_remainder;

    // one candidate per byte count, each a pair of matrix products
    always_comb begin
        for (int n = 0; n < CRC_BYTES; n++) begin
            cand[n] = crc_mat_mul(CRC_STATE_MAT[n], base)
                    ^ crc_mat_mul(CRC_DATA_MAT[n], i_item.data_word);
        end
    end

    // byte count decode, counts above four saturate
    always_comb begin
        fold_en = 1'b1;
        lane    = 2'd0;
        case (i_item.byte_count) inside
            3'd0: begin
                fold_en = 1'b0;
            end
            [3'd1:3'd4]: begin
                lane = 2'(i_item.byte_count - 3'd1);
            end
            default: begin
                lane = 2'(CRC_BYTES - 1);
            end
        endcase
    end

    assign n_remainder = fold_en ? cand[lane] : base;
    assign o_next_rem  = n_remainder;

    // running remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remainder <= CRC_ALL_ONES;
        end else if (i_adv) begin
            r_remainder <= n_remainder;
        end
    end

endmodule

// ===== src/crc32c_out_stage.sv =====
// result register: holds the finalized crc until the downstream side takes it
// depends on crc32c_pkg
module crc32c_out_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [31:0] i_next_rem,
    output logic        o_free,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_crc_value
);
    import crc32c_pkg::*;

    logic        r_valid;
    logic        n_valid;
    logic [31:0] r_crc;

    // can load when empty or when the held result leaves this cycle
    assign o_free = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_adv) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // finalized value is the inverted remainder
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_crc <= i_next_rem ^ CRC_ALL_ONES;
        end
    end

    assign o_out_valid = r_valid;
    assign o_crc_value = r_crc;

endmodule

// ===== src/crc32c_word_engine_top.sv =====
// top level of the crc32c word engine: input register, matrix update, result register
// depends on crc32c_pkg, crc32c_in_stage, crc32c_update, crc32c_out_stage
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_data_word i_byte_count i_start_req i_seed
//  result  | out       | o_out_valid / i_out_ready | o_crc_value
//
// one transaction per clock while results are taken; each passes the input and result registers
// the remainder is updated in one pass through a 64-input xor matrix per bit
// synchronous active-low reset sets the remainder to all ones and empties both registers
// a stalled result holds while the input register still takes one more transaction
module crc32c_word_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_start_req,
    input  logic [31:0] i_seed,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_crc_value
);
    import crc32c_pkg::*;

    t_crc_item   in_item;
    t_crc_item   held_item;
    logic        item_valid;
    logic        out_free;
    logic        adv;
    logic [31:0] next_rem;

    assign in_item.data_word  = i_data_word;
    assign in_item.byte_count = i_byte_count;
    assign in_item.start_req  = i_start_req;
    assign in_item.seed       = i_seed;

    // held item moves into the result register when that register can load
    assign adv = item_valid && out_free;

    crc32c_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_item       (in_item),
        .i_adv        (adv),
        .o_item_valid (item_valid),
        .o_item       (held_item)
    );

    crc32c_update u_upd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_item     (held_item),
        .o_next_rem (next_rem)
    );

    crc32c_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_next_rem  (next_rem),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_crc_value (o_crc_value)
    );

endmodule

// ===== src/crc32c_word_engine_top_chk.sv =====
// port-level checker for the crc32c word engine, bound to the top level
// depends on crc32c_word_engine_top_defines.svh and crc32c_word_engine_top
`include "crc32c_word_engine_top_defines.svh"

module crc32c_word_engine_top_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [31:0] i_data_word,
    input logic [2:0]  i_byte_count,
    input logic        i_start_req,
    input logic [31:0] i_seed,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_crc_value
);

    // a stalled result transaction stays valid with the same value
    `CRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_crc_value), "result changed while stalled")

    // input side only stalls when both registers are full and the result is blocked
    `CRC_ASSERT_IMPLY(a_ready_cause, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready, "input stalled without a blocked result")

    // no result is offered in the first cycle after reset
    `CRC_ASSERT_IMPLY(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid && o_in_ready, "pipeline not empty after reset")

endmodule

bind crc32c_word_engine_top crc32c_word_engine_top_chk u_chk (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench for crc32c_word_engine_top: random and directed word streams checked against a crc tracker
// depends on crc32c_pkg for the reflected polynomial and all-ones constants and on the engine rtl

module testbench;
    import crc32c_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int HOLD_CYCLES   = 250;
    localparam int HOLD_AFTER    = 700;

    // running crc tracker: predicts one crc per accepted transaction and holds them in order
    class crc_tracker;
        logic [31:0] running_rem;
        logic [31:0] pending_crcs[$];
        int          failures;

        function new();
            running_rem = CRC_ALL_ONES;
            failures    = 0;
        endfunction

        // lsb-first bitwise division of the low n bytes into the remainder
        function automatic logic [31:0] fold_bytes(logic [31:0] rem, logic [31:0] word,
                                                   int unsigned n);
            logic [31:0] r;
            logic [31:0] w;
            r = rem;
            w = word;
            for (int k = 0; k < n; k++) begin
                r = r ^ {24'd0, w[7:0]};
                w = w >> 8;
                for (int b = 0; b < 8; b++) begin
                    r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
                end
            end
            return r;
        endfunction

        // accepted input transaction: update the remainder and queue the finalized crc
        function void absorb_word(logic [31:0] word, logic [2:0] cnt, logic start,
                                  logic [31:0] seed);
            int unsigned n;
            logic [31:0] r;
            n = (cnt > 3'd4) ? 4 : int'(cnt);
            r = start ? (seed ^ CRC_ALL_ONES) : running_rem;
            running_rem = fold_bytes(r, word, n);
            pending_crcs.push_back(running_rem ^ CRC_ALL_ONES);
        endfunction

        // accepted result transaction: compare with the oldest queued crc
        function void match_crc(logic [31:0] crc);
            logic [31:0] exp_crc;
            if (pending_crcs.size() == 0) begin
                $display("%0t unexpected crc result: expected none actual %08h", $time, crc);
                failures++;
            end else begin
                exp_crc = pending_crcs.pop_front();
                if (crc !== exp_crc) begin
                    $display("%0t crc mismatch: expected %08h actual %08h",
                             $time, exp_crc, crc);
                    failures++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_data_word;
    logic [2:0]  i_byte_count;
    logic        i_start_req;
    logic [31:0] i_seed;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_crc_value;

    crc_tracker tracker = new();
    int         words_accepted = 0;
    int         quiet_cycles   = 0;

    crc32c_word_engine_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_start_req  (i_start_req),
        .i_seed       (i_seed),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_crc_value  (o_crc_value)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // monitors for both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            tracker.absorb_word(i_data_word, i_byte_count, i_start_req, i_seed);
            words_accepted <= words_accepted + 1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.match_crc(o_crc_value);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n && !((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))) begin
            quiet_cycles <= quiet_cycles + 1;
        end else begin
            quiet_cycles <= 0;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // present one input transaction after an optional gap and wait for acceptance
    task automatic offer_word(input logic [31:0] word, input logic [2:0] cnt,
                              input logic start, input logic [31:0] seed, input int gap);
        if (gap > 0) begin
            i_in_valid   <= 1'b0;
            i_data_word  <= $urandom;
            i_byte_count <= 3'($urandom_range(0, 7));
            i_start_req  <= 1'($urandom_range(0, 1));
            i_seed       <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        i_data_word  <= word;
        i_byte_count <= cnt;
        i_start_req  <= start;
        i_seed       <= seed;
        i_in_valid   <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!(i_in_valid && o_in_ready));
    endtask

    // byte count for a message body: mostly full words
    function automatic logic [2:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return 3'd4;
        end else if (r < 95) begin
            return 3'($urandom_range(1, 3));
        end
        return 3'($urandom_range(0, 7));
    endfunction

    // result side: random ready with one long hold-off to back up the pipeline
    initial begin
        int  run;
        bit  held;
        held = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && words_accepted >= HOLD_AFTER) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 16);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            i_out_ready <= 1'b0;
            repeat (run) @(posedge i_clk);
        end
    end

    // input side: reset, directed words, random messages, drain
    initial begin
        int          sent;
        int          len;
        bit          busy_burst;
        logic [31:0] seed;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_word  <= '0;
        i_byte_count <= '0;
        i_start_req  <= 1'b0;
        i_seed       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // continuation straight out of reset
        offer_word(32'h0000_0000, 3'd4, 1'b0, 32'hffff_ffff, 0);
        // check string "123456789" from seed zero
        offer_word(32'h3433_3231, 3'd4, 1'b1, 32'h0000_0000, 0);
        offer_word(32'h3837_3635, 3'd4, 1'b0, 32'h0000_0000, 1);
        offer_word(32'h0000_0039, 3'd1, 1'b0, 32'hffff_ffff, 0);
        // zero byte count, with and without start
        offer_word(32'hffff_ffff, 3'd0, 1'b0, 32'h0000_0000, 0);
        offer_word(32'hdead_beef, 3'd0, 1'b1, 32'h1234_5678, 0);
        offer_word(32'hffff_ffff, 3'd4, 1'b0, 32'h0000_0000, 2);
        // counts above four saturate
        offer_word(32'ha5a5_5a5a, 3'd5, 1'b1, 32'hffff_ffff, 0);
        offer_word(32'h5a5a_a5a5, 3'd6, 1'b0, 32'h0000_0000, 0);
        offer_word(32'hffff_ffff, 3'd7, 1'b0, 32'hffff_ffff, 0);
        // every partial count and field extremes
        offer_word(32'hffff_ffff, 3'd1, 1'b1, 32'h0000_0000, 0);
        offer_word(32'hffff_ffff, 3'd2, 1'b0, 32'h0000_0000, 0);
        offer_word(32'hffff_ffff, 3'd3, 1'b0, 32'h0000_0000, 3);
        offer_word(32'h0000_0000, 3'd3, 1'b1, 32'hffff_ffff, 0);
        offer_word(32'h0000_0000, 3'd2, 1'b0, 32'hffff_ffff, 0);
        offer_word(32'h0000_0000, 3'd1, 1'b0, 32'hffff_ffff, 0);
        offer_word(32'h8000_0001, 3'd4, 1'b1, 32'h8000_0001, 0);
        offer_word(32'h7fff_fffe, 3'd4, 1'b1, 32'h7fff_fffe, 0);
        offer_word(32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000, 0);

        // random messages with occasional noise transactions
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                offer_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           $urandom, pick_gap());
                sent++;
            end else begin
                len        = $urandom_range(1, 10);
                busy_burst = ($urandom_range(0, 4) == 0);
                case ($urandom_range(0, 3))
                    0: begin
                        seed = 32'h0000_0000;
                    end
                    1: begin
                        seed = 32'hffff_ffff;
                    end
                    default: begin
                        seed = $urandom;
                    end
                endcase
                for (int k = 0; k < len; k++) begin
                    offer_word($urandom, pick_count(), (k == 0), (k == 0) ? seed : $urandom,
                               busy_burst ? 0 : pick_gap());
                    sent++;
                end
            end
        end
        i_in_valid <= 1'b0;

        // drain outstanding results
        while (tracker.pending_crcs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
